@@ sv/mler_pkg.sv @@
// ----------------------------------------------------------------------------
// mler_pkg
// Shared constants and types of the loop event recorder and player.
// ----------------------------------------------------------------------------
package mler_pkg;

    localparam int STORE_DEPTH_DEF  = 256;
    localparam int MAX_PER_TICK_DEF = 64;
    localparam int TICKS_PER_BEAT   = 24;

    localparam logic [2:0] OP_REC_START  = 3'd0;
    localparam logic [2:0] OP_REC_CLOCK  = 3'd1;
    localparam logic [2:0] OP_NOTE       = 3'd2;
    localparam logic [2:0] OP_PLAY_START = 3'd3;
    localparam logic [2:0] OP_PLAY_TICK  = 3'd4;

    localparam logic CFG_BARS  = 1'b0;
    localparam logic CFG_BEATS = 1'b1;

    typedef struct packed {
        logic       kind;
        logic [6:0] note;
        logic [6:0] vel;
        logic [4:0] chan;
        logic [14:0] tstamp;
    } entry_t;

    // window = bars * beats * 24, operands clamped
    function automatic logic [14:0] window_limit(input logic [6:0] b, input logic [4:0] p);
        logic [6:0]  bc;
        logic [4:0]  pc;
        logic [10:0] prod;
        bc = (b == 7'd0) ? 7'd1 : ((b > 7'd64) ? 7'd64 : b);
        pc = (p == 5'd0) ? 5'd1 : ((p > 5'd16) ? 5'd16 : p);
        prod = 11'(bc) * 11'(pc);
        return 15'({prod, 4'b0} + {prod, 3'b0});
    endfunction

endpackage

@@ sv/midi_loop_event_recorder_player_unit.sv @@
// ----------------------------------------------------------------------------
// midi_loop_event_recorder_player_unit
// Records note messages into a time-ordered store and plays them as loops.
// ----------------------------------------------------------------------------
// Sequencer around one single-port event memory. Clock, start and play-start
// transactions, and a note that is dropped or that overflows the store, are
// handled without leaving the idle state. A stored note scans the store for
// its slot (S_SCAN and S_SCANW per entry read) and then shifts the tail up
// one entry at a time (S_SHIFT and S_SHIFTW per entry). A play tick reads
// the entries in turn (S_PLAY and S_PLAYW) and holds each due entry back
// until the next read or the end of the store shows whether it ends the
// run. A result that waits on a stalled output holds the sequencer. No
// clearing pass after reset: the fill count bounds every read.
module midi_loop_event_recorder_player_unit #(
    parameter int STORE_DEPTH  = mler_pkg::STORE_DEPTH_DEF,
    parameter int MAX_PER_TICK = mler_pkg::MAX_PER_TICK_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_write,
    input  logic        cfg_index,
    input  logic [6:0]  cfg_data,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [2:0]  operation,
    input  logic        message_kind,
    input  logic [6:0]  note_number,
    input  logic [6:0]  velocity,
    input  logic [4:0]  channel,
    input  logic [7:0]  repeat_count,
    output logic        out_valid,
    input  logic        out_stall,
    output logic        out_kind,
    output logic [6:0]  out_note,
    output logic [6:0]  out_velocity,
    output logic [4:0]  out_channel,
    output logic [14:0] out_time,
    output logic        last_in_run,
    output logic        overflow,
    output logic        loop_done
);

    localparam int AW = $clog2(STORE_DEPTH);
    localparam int CW = AW + 1;
    localparam int NW = $clog2(MAX_PER_TICK + 1);

    typedef enum logic [7:0] {
        S_IDLE   = 8'b00000001,
        S_SCAN   = 8'b00000010,
        S_SCANW  = 8'b00000100,
        S_SHIFT  = 8'b00001000,
        S_SHIFTW = 8'b00010000,
        S_PLAY   = 8'b00100000,
        S_PLAYW  = 8'b01000000,
        S_FLUSH  = 8'b10000000
    } state_t;

    state_t           state_reg, state_next;
    logic [6:0]       bars_reg, bars_next;
    logic [4:0]       beats_reg, beats_next;
    logic [CW-1:0]    count_reg, count_next;
    logic [15:0]      pos_reg, pos_next;
    logic             rec_reg, rec_next;
    logic [14:0]      tick_reg, tick_next;
    logic [CW-1:0]    pidx_reg, pidx_next;
    logic [7:0]       passes_reg, passes_next;
    logic [CW-1:0]    idx_reg, idx_next;
    logic [CW-1:0]    slot_reg, slot_next;
    logic [NW-1:0]    n_reg, n_next;
    mler_pkg::entry_t new_reg, new_next;
    mler_pkg::entry_t hold_reg, hold_next;
    logic             fin_done_reg, fin_done_next;
    logic             ov_reg, ov_next;
    mler_pkg::entry_t ob_reg, ob_next;
    logic             ob_last_reg, ob_last_next, ob_ovf_reg, ob_ovf_next;
    logic             ob_done_reg, ob_done_next;

    logic             mem_we;
    logic [AW-1:0]    mem_addr;
    mler_pkg::entry_t mem_wdata, mem_rdata;
    logic [14:0]      limit;
    logic             in_acc, out_free;

    mler_store #(.DEPTH(STORE_DEPTH), .AW(AW)) u_store (
        .clk   (clk),
        .we    (mem_we),
        .addr  (mem_addr),
        .wdata (mem_wdata),
        .rdata (mem_rdata)
    );

    assign limit    = mler_pkg::window_limit(bars_reg, beats_reg);
    assign in_stall = (state_reg != S_IDLE) || (ov_reg && out_stall);
    assign in_acc   = in_valid && !in_stall;
    assign out_free = !ov_reg || !out_stall;

    always_comb
    begin
        state_next    = state_reg;
        bars_next     = bars_reg;
        beats_next    = beats_reg;
        count_next    = count_reg;
        pos_next      = pos_reg;
        rec_next      = rec_reg;
        tick_next     = tick_reg;
        pidx_next     = pidx_reg;
        passes_next   = passes_reg;
        idx_next      = idx_reg;
        slot_next     = slot_reg;
        n_next        = n_reg;
        new_next      = new_reg;
        hold_next     = hold_reg;
        fin_done_next = fin_done_reg;
        ov_next       = ov_reg && out_stall;
        ob_next       = ob_reg;
        ob_last_next  = ob_last_reg;
        ob_ovf_next   = ob_ovf_reg;
        ob_done_next  = ob_done_reg;
        mem_we        = 1'b0;
        mem_addr      = idx_reg[AW-1:0];
        mem_wdata     = mem_rdata;

        if (cfg_write)
        begin
            unique case (cfg_index)
                mler_pkg::CFG_BARS:  bars_next  = cfg_data;
                mler_pkg::CFG_BEATS: beats_next = cfg_data[4:0];
                default: ;
            endcase
        end

        unique case (state_reg)
            S_IDLE:
            begin
                if (in_acc)
                begin
                    unique case (operation)
                        mler_pkg::OP_REC_START:
                        begin
                            count_next = '0;
                            pos_next   = 16'hFFFF;
                            rec_next   = 1'b1;
                        end
                        mler_pkg::OP_REC_CLOCK:
                        begin
                            if (rec_reg)
                            begin
                                pos_next = pos_reg + 16'd1;
                                if (pos_next > {1'b0, limit})
                                begin
                                    rec_next = 1'b0;
                                end
                            end
                        end
                        mler_pkg::OP_NOTE:
                        begin
                            new_next = '{message_kind, note_number, velocity, channel,
                                         pos_reg[14:0]};
                            if (rec_reg && pos_reg != 16'hFFFF &&
                                !(message_kind && pos_reg >= {1'b0, limit}))
                            begin
                                if (count_reg >= CW'(STORE_DEPTH))
                                begin
                                    ov_next      = 1'b1;
                                    ob_next      = new_next;
                                    ob_last_next = 1'b1;
                                    ob_ovf_next  = 1'b1;
                                    ob_done_next = 1'b0;
                                end
                                else
                                begin
                                    idx_next   = '0;
                                    state_next = S_SCAN;
                                end
                            end
                        end
                        mler_pkg::OP_PLAY_START:
                        begin
                            passes_next = repeat_count;
                            tick_next   = '0;
                            pidx_next   = '0;
                        end
                        mler_pkg::OP_PLAY_TICK:
                        begin
                            if (passes_reg != 8'd0)
                            begin
                                n_next     = '0;
                                state_next = S_PLAY;
                            end
                        end
                        default: ;
                    endcase
                end
            end
            S_SCAN:
            begin
                if (idx_reg >= count_reg)
                begin
                    mem_we     = 1'b1;
                    mem_wdata  = new_reg;
                    count_next = count_reg + CW'(1);
                    state_next = S_IDLE;
                end
                else
                begin
                    state_next = S_SCANW;
                end
            end
            S_SCANW:
            begin
                if (mem_rdata.tstamp >= new_reg.tstamp)
                begin
                    slot_next  = idx_reg;
                    idx_next   = count_reg;
                    state_next = S_SHIFT;
                end
                else
                begin
                    idx_next   = idx_reg + CW'(1);
                    state_next = S_SCAN;
                end
            end
            S_SHIFT:
            begin
                // walk idx down from count to the slot, then drop the new entry in
                if (idx_reg == slot_reg)
                begin
                    mem_we     = 1'b1;
                    mem_addr   = idx_reg[AW-1:0];
                    mem_wdata  = new_reg;
                    count_next = count_reg + CW'(1);
                    state_next = S_IDLE;
                end
                else
                begin
                    mem_addr   = AW'(idx_reg - CW'(1));
                    state_next = S_SHIFTW;
                end
            end
            S_SHIFTW:
            begin
                mem_we    = 1'b1;
                mem_addr  = idx_reg[AW-1:0];
                mem_wdata = mem_rdata;
                idx_next  = idx_reg - CW'(1);
                state_next = S_SHIFT;
            end
            S_PLAY:
            begin
                if (out_free)
                begin
                    if (pidx_reg < count_reg)
                    begin
                        mem_addr   = pidx_reg[AW-1:0];
                        state_next = S_PLAYW;
                    end
                    else
                    begin
                        passes_next = passes_reg - 8'd1;
                        pidx_next   = '0;
                        tick_next   = '0;
                        if (passes_reg == 8'd1 && n_reg == '0)
                        begin
                            ov_next      = 1'b1;
                            ob_next      = '0;
                            ob_last_next = 1'b1;
                            ob_ovf_next  = 1'b0;
                            ob_done_next = 1'b1;
                        end
                        state_next = S_IDLE;
                    end
                end
            end
            S_PLAYW:
            begin
                if (mem_rdata.tstamp <= tick_reg && n_reg < NW'(MAX_PER_TICK))
                begin
                    if (n_reg != '0)
                    begin
                        ov_next      = 1'b1;
                        ob_next      = hold_reg;
                        ob_last_next = 1'b0;
                        ob_ovf_next  = 1'b0;
                        ob_done_next = 1'b0;
                    end
                    hold_next      = mem_rdata;
                    hold_next.kind = mem_rdata.kind && (mem_rdata.vel != 7'd0);
                    n_next         = n_reg + NW'(1);
                    pidx_next      = pidx_reg + CW'(1);
                    if (pidx_next >= count_reg)
                    begin
                        passes_next   = passes_reg - 8'd1;
                        pidx_next     = '0;
                        tick_next     = '0;
                        fin_done_next = (passes_reg == 8'd1);
                        state_next    = S_FLUSH;
                    end
                    else
                    begin
                        state_next = S_PLAY;
                    end
                end
                else
                begin
                    if (!(n_reg >= NW'(MAX_PER_TICK) && mem_rdata.tstamp <= tick_reg))
                    begin
                        tick_next = tick_reg + 15'd1;
                    end
                    if (n_reg != '0)
                    begin
                        ov_next      = 1'b1;
                        ob_next      = hold_reg;
                        ob_last_next = 1'b1;
                        ob_ovf_next  = 1'b0;
                        ob_done_next = 1'b0;
                    end
                    state_next = S_IDLE;
                end
            end
            S_FLUSH:
            begin
                if (out_free)
                begin
                    ov_next      = 1'b1;
                    ob_next      = hold_reg;
                    ob_last_next = 1'b1;
                    ob_ovf_next  = 1'b0;
                    ob_done_next = fin_done_reg;
                    state_next   = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_IDLE;
            bars_reg   <= 7'd4;
            beats_reg  <= 5'd4;
            count_reg  <= '0;
            pos_reg    <= 16'hFFFF;
            rec_reg    <= 1'b0;
            tick_reg   <= '0;
            pidx_reg   <= '0;
            passes_reg <= '0;
            ov_reg     <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            bars_reg   <= bars_next;
            beats_reg  <= beats_next;
            count_reg  <= count_next;
            pos_reg    <= pos_next;
            rec_reg    <= rec_next;
            tick_reg   <= tick_next;
            pidx_reg   <= pidx_next;
            passes_reg <= passes_next;
            ov_reg     <= ov_next;
        end
    end

    always_ff @(posedge clk)
    begin
        idx_reg      <= idx_next;
        n_reg        <= n_next;
        new_reg      <= new_next;
        slot_reg     <= slot_next;
        hold_reg     <= hold_next;
        fin_done_reg <= fin_done_next;
        ob_reg       <= ob_next;
        ob_last_reg  <= ob_last_next;
        ob_ovf_reg   <= ob_ovf_next;
        ob_done_reg  <= ob_done_next;
    end

    assign out_valid    = ov_reg;
    assign out_kind     = ob_reg.kind;
    assign out_note     = ob_reg.note;
    assign out_velocity = ob_reg.vel;
    assign out_channel  = ob_reg.chan;
    assign out_time     = ob_reg.tstamp;
    assign last_in_run  = ob_last_reg;
    assign overflow     = ob_ovf_reg;
    assign loop_done    = ob_done_reg;

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CW'(STORE_DEPTH))
        else $error("fill count beyond store depth");

    a_busy_stall: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg != S_IDLE) |-> in_stall)
        else $error("input taken while busy");

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_stall) |=> out_valid)
        else $error("result lost under stall");

endmodule

@@ sv/mler_store.sv @@
// ----------------------------------------------------------------------------
// mler_store
// Event store: single-port synchronous memory with a registered read.
// ----------------------------------------------------------------------------
module mler_store #(
    parameter int DEPTH = mler_pkg::STORE_DEPTH_DEF,
    parameter int AW    = $clog2(DEPTH)
) (
    input  logic                 clk,
    input  logic                 we,
    input  logic [AW-1:0]        addr,
    input  mler_pkg::entry_t     wdata,
    output mler_pkg::entry_t     rdata
);

    mler_pkg::entry_t mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[addr] <= wdata;
        end
        rdata <= mem[addr];
    end

endmodule
